/* design/bflg_pkg.sv */
// shared types, constants and codes for the battery level filter guard
package bflg_pkg;

    localparam int unsigned WINDOW_DEPTH_DEF = 10;

    localparam int unsigned RAW_W     = 8;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned LEVEL_W   = 7;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 8;

    localparam logic [LEVEL_W-1:0] PCT_MAX = LEVEL_W'(100);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // fewer samples than this give the plain mean
    localparam int unsigned TRIM_MIN_FILL = 3;
    // one maximum and one minimum dropped
    localparam int unsigned TRIM_DROP = 2;

    localparam logic [LEVEL_W-1:0] SHUTDOWN_LEVEL_RST  = LEVEL_W'(10);
    localparam logic [LEVEL_W-1:0] WARN_LEVEL_RST      = LEVEL_W'(15);
    localparam logic [COUNT_W-1:0] LOW_COUNT_LIMIT_RST = COUNT_W'(3);

    // charger status codes
    localparam logic [STATUS_W-1:0] CHG_NOT  = 2'd0;
    localparam logic [STATUS_W-1:0] CHG_ING  = 2'd1;
    localparam logic [STATUS_W-1:0] CHG_DONE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_LEVEL      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_COUNT_LIMIT = 2'd2;

    typedef struct packed {
        logic [RAW_W-1:0]    raw_percent;
        logic [STATUS_W-1:0] chg_state;
    } bflg_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               low_warning;
        logic               shutdown_request;
        logic               unplug_event;
    } bflg_out_t;

endpackage

/* design/bflg_ram.sv */
// generic single-write, single-read ram with registered read data
module bflg_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/bflg_div.sv */
// iterative restoring divider, one quotient bit per cycle, quotient known to fit Q_W bits
module bflg_div #(
    parameter int unsigned NUM_W = 10,
    parameter int unsigned DEN_W = 4,
    parameter int unsigned Q_W   = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [Q_W-1:0]   quo
);

    localparam int unsigned CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[Q_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // upper bits are below the divisor since the quotient fits Q_W bits
            rem_next  = DEN_W'(num >> Q_W);
            quo_next  = num[Q_W-1:0];
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(Q_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* design/battery_level_filter_guard.sv */
// battery level filter guard: sample ring in ram, trimmed mean, direction hold, low guard
// path: charging or on-battery words go through ring scan (one entry per cycle), divider
//   start and divider wait to the finish state; other status goes straight to finish
// flow: one word at a time; a new word is taken once the result is loaded into the
//   output register, which may still wait
// reset: synchronous active low aresetn clears control state, fill, slot and low counts and
//   configuration to defaults; ring contents stay, only entries below the fill count are read
module battery_level_filter_guard #(
    parameter int unsigned WINDOW_DEPTH = bflg_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input word channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  bflg_pkg::bflg_in_t                   s_data,
    // result word channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output bflg_pkg::bflg_out_t                  m_data,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [bflg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bflg_pkg::CFG_DAT_W-1:0]       cfg_wdata
);

    import bflg_pkg::*;

    // ring index, fill count and sum widths follow the window depth
    localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
    localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SUM_W = $clog2(WINDOW_DEPTH * 100 + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_DIVS = 5'b00100,
        ST_DIVW = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [LEVEL_W-1:0] shutdown_level_reg, shutdown_level_next;
    logic [LEVEL_W-1:0] warn_level_reg, warn_level_next;
    logic [COUNT_W-1:0] low_count_limit_reg, low_count_limit_next;

    // persistent state
    logic [IDX_W-1:0]    write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [LEVEL_W-1:0]  held_reg, held_next;
    logic [COUNT_W-1:0]  low_cnt_reg, low_cnt_next;
    logic [STATUS_W-1:0] last_status_reg, last_status_next;

    // per-word working registers
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [LEVEL_W-1:0]  hi_reg, hi_next;
    logic [LEVEL_W-1:0]  lo_reg, lo_next;
    logic [LEVEL_W-1:0]  filt_reg, filt_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    bflg_out_t           out_reg, out_next;

    // ram and divider hookup
    logic                ram_wr_en;
    logic [LEVEL_W-1:0]  sample;
    logic                issuing;
    logic [LEVEL_W-1:0]  rd_data;
    logic                div_start;
    logic [SUM_W-1:0]    div_num;
    logic [CNT_W-1:0]    div_den;
    logic                div_done;
    logic [LEVEL_W-1:0]  div_quo;

    // misc combinational
    logic                s_fire;
    logic                in_has_sample;
    logic                fin_go;
    logic                on_batt;
    logic                has_sample;
    logic [LEVEL_W-1:0]  held_base;
    logic [LEVEL_W-1:0]  held_upd;
    logic [COUNT_W-1:0]  low_cnt_inc;

    assign s_ready       = state_reg == ST_IDLE;
    assign s_fire        = s_valid && s_ready;
    assign in_has_sample = (s_data.chg_state == CHG_NOT) ||
                           (s_data.chg_state == CHG_ING);
    // clamp raw gauge reading to full scale
    assign sample        = (s_data.raw_percent > RAW_W'(PCT_MAX)) ? PCT_MAX
                                                                  : s_data.raw_percent[LEVEL_W-1:0];
    assign ram_wr_en     = s_fire && in_has_sample;
    // read entries 0 .. fill-1, one per cycle
    assign issuing       = (state_reg == ST_SCAN) && (issue_reg < fill_reg);

    bflg_ram #(
        .DATA_W (LEVEL_W),
        .DEPTH  (WINDOW_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (write_slot_reg),
        .wr_data (sample),
        .rd_en   (issuing),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // plain mean under three samples, else trimmed mean
    always_comb begin
        if (fill_reg < CNT_W'(TRIM_MIN_FILL)) begin
            div_num = sum_reg;
            div_den = fill_reg;
        end else begin
            div_num = sum_reg - SUM_W'(hi_reg) - SUM_W'(lo_reg);
            div_den = fill_reg - CNT_W'(TRIM_DROP);
        end
    end

    assign div_start = state_reg == ST_DIVS;

    bflg_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W),
        .Q_W   (LEVEL_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // direction hold and low guard, evaluated when the result is loaded
    assign has_sample  = (status_reg == CHG_NOT) || (status_reg == CHG_ING);
    assign on_batt     = status_reg == CHG_NOT;
    // a held zero reloads from the filtered value
    assign held_base   = (held_reg == '0) ? filt_reg : held_reg;
    assign low_cnt_inc = (low_cnt_reg == COUNT_MAX) ? low_cnt_reg
                                                    : low_cnt_reg + COUNT_W'(1);

    always_comb begin
        if (!has_sample) begin
            held_upd = held_reg;
        end else if (on_batt) begin
            held_upd = (filt_reg < held_base) ? filt_reg : held_base;
        end else begin
            held_upd = (filt_reg > held_base) ? filt_reg : held_base;
        end
    end

    assign fin_go = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next           = state_reg;
        shutdown_level_next  = shutdown_level_reg;
        warn_level_next      = warn_level_reg;
        low_count_limit_next = low_count_limit_reg;
        write_slot_next      = write_slot_reg;
        fill_next            = fill_reg;
        held_next            = held_reg;
        low_cnt_next         = low_cnt_reg;
        last_status_next     = last_status_reg;
        status_next          = status_reg;
        issue_next           = issue_reg;
        rd_pend_next         = issuing;
        sum_next             = sum_reg;
        hi_next              = hi_reg;
        lo_next              = lo_reg;
        filt_next            = filt_reg;
        out_next             = out_reg;
        m_valid_next         = m_valid_reg && !m_ready;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SHUTDOWN_LEVEL:  shutdown_level_next  = cfg_wdata[LEVEL_W-1:0];
                CFG_WARN_LEVEL:      warn_level_next      = cfg_wdata[LEVEL_W-1:0];
                CFG_LOW_COUNT_LIMIT: low_count_limit_next = cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    status_next = s_data.chg_state;
                    issue_next  = '0;
                    sum_next    = '0;
                    hi_next     = '0;
                    lo_next     = PCT_MAX;
                    if (in_has_sample) begin
                        // push into the ring; slot wraps, fill saturates
                        write_slot_next = (write_slot_reg == IDX_W'(WINDOW_DEPTH - 1))
                                          ? '0 : write_slot_reg + IDX_W'(1);
                        fill_next       = (fill_reg == CNT_W'(WINDOW_DEPTH))
                                          ? fill_reg : fill_reg + CNT_W'(1);
                        state_next      = ST_SCAN;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                if (issuing) begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (rd_pend_reg) begin
                    sum_next = sum_reg + SUM_W'(rd_data);
                    hi_next  = (rd_data > hi_reg) ? rd_data : hi_reg;
                    lo_next  = (rd_data < lo_reg) ? rd_data : lo_reg;
                    // last read data arrives once nothing more is issued
                    if (!issuing) begin
                        state_next = ST_DIVS;
                    end
                end
            end
            ST_DIVS: begin
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_done) begin
                    filt_next  = (div_quo > PCT_MAX) ? PCT_MAX : div_quo;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    held_next                 = held_upd;
                    last_status_next          = status_reg;
                    out_next.level            = held_upd;
                    out_next.low_warning      = 1'b0;
                    out_next.shutdown_request = 1'b0;
                    out_next.unplug_event     = 1'b0;
                    if (on_batt) begin
                        out_next.unplug_event = (last_status_reg == CHG_ING) ||
                                                (last_status_reg == CHG_DONE);
                        out_next.low_warning  = held_upd <= warn_level_reg;
                        if (held_upd <= shutdown_level_reg) begin
                            low_cnt_next              = low_cnt_inc;
                            out_next.shutdown_request = low_cnt_inc > low_count_limit_reg;
                        end else begin
                            low_cnt_next = '0;
                        end
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            shutdown_level_reg  <= SHUTDOWN_LEVEL_RST;
            warn_level_reg      <= WARN_LEVEL_RST;
            low_count_limit_reg <= LOW_COUNT_LIMIT_RST;
            write_slot_reg      <= '0;
            fill_reg            <= '0;
            held_reg            <= '0;
            low_cnt_reg         <= '0;
            last_status_reg     <= CHG_NOT;
            rd_pend_reg         <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg           <= state_next;
            shutdown_level_reg  <= shutdown_level_next;
            warn_level_reg      <= warn_level_next;
            low_count_limit_reg <= low_count_limit_next;
            write_slot_reg      <= write_slot_next;
            fill_reg            <= fill_next;
            held_reg            <= held_next;
            low_cnt_reg         <= low_cnt_next;
            last_status_reg     <= last_status_next;
            rd_pend_reg         <= rd_pend_next;
            m_valid_reg         <= m_valid_next;
        end
        status_reg <= status_next;
        issue_reg  <= issue_next;
        sum_reg    <= sum_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        filt_reg   <= filt_next;
        out_reg    <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // fill count never passes the ring depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("fill count above ring depth");

    // until the ring is full the write slot tracks the fill count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg < CNT_W'(WINDOW_DEPTH)) |-> (CNT_W'(write_slot_reg) == fill_reg))
        else $error("write slot out of step with fill count");

    // ram read data is only pending during the ring scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == ST_SCAN))
        else $error("ring read pending outside scan");

    // loading a result never overwrites one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && m_valid_reg && !m_ready) |=> (state_reg == ST_FIN))
        else $error("result loaded over a waiting word");

endmodule

/* bench/battery_level_filter_guard_tb.sv */
// self-checking testbench for the battery level filter guard, with a predictor in the bench
module battery_level_filter_guard_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bflg_pkg::*;

    localparam int unsigned DEPTH = WINDOW_DEPTH_DEF;
    // status three has no meaning; no sample as for complete, but no unplug after it
    localparam logic [STATUS_W-1:0] CHG_UNDEF = 2'd3;

    // quiet cycles after the last result: ring scan plus divider, with margin
    localparam int DRAIN_CYCLES    = DEPTH + 24;
    localparam int WATCHDOG_LIMIT  = 4000;
    // one long receiver hold-off once this many results have been checked
    localparam int PRESSURE_AT     = 1400;
    localparam int PRESSURE_CYCLES = 400;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    bflg_in_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    bflg_out_t            m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    battery_level_filter_guard #(
        .WINDOW_DEPTH(DEPTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor state: a private copy of the block's registers and memory
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0]  cfg_shut_pct  = SHUTDOWN_LEVEL_RST;
    logic [LEVEL_W-1:0]  cfg_warn_pct  = WARN_LEVEL_RST;
    logic [COUNT_W-1:0]  cfg_low_limit = LOW_COUNT_LIMIT_RST;

    logic [LEVEL_W-1:0]  smp_ring [DEPTH];
    int unsigned         smp_slot = 0;
    int unsigned         smp_fill = 0;
    logic [LEVEL_W-1:0]  hold_pct = '0;
    logic [COUNT_W-1:0]  low_run = '0;
    logic [STATUS_W-1:0] prev_status = CHG_NOT;

    bflg_in_t  word_queue[$];    // words waiting for the driver
    bflg_out_t level_expect[$];  // predicted results, oldest first

    int words_issued  = 0;
    int results_done  = 0;
    int fail_count    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // write a sample into the ring and return the (trimmed) mean of the filled part
    function automatic logic [LEVEL_W-1:0] push_and_average(input logic [LEVEL_W-1:0] smp);
        int unsigned total;
        int unsigned top;
        int unsigned bottom;
        int unsigned avg;
        if (smp_fill < DEPTH) begin
            smp_fill++;
        end
        smp_ring[smp_slot] = smp;
        smp_slot = (smp_slot + 1 >= DEPTH) ? 0 : smp_slot + 1;
        total  = 0;
        top    = 0;
        bottom = PCT_MAX;
        // the ring fills from slot zero, so the first fill entries are the live ones
        for (int i = 0; i < smp_fill; i++) begin
            total += smp_ring[i];
            if (smp_ring[i] > top) begin
                top = smp_ring[i];
            end
            if (smp_ring[i] < bottom) begin
                bottom = smp_ring[i];
            end
        end
        if (smp_fill < TRIM_MIN_FILL) begin
            avg = total / smp_fill;
        end else begin
            // drop one maximum and one minimum
            avg = (total - top - bottom) / (smp_fill - TRIM_DROP);
        end
        if (avg > PCT_MAX) begin
            avg = PCT_MAX;
        end
        return LEVEL_W'(avg);
    endfunction

    // expected result for one accepted input word; advances the predictor state
    function automatic bflg_out_t predict_level_word(input bflg_in_t w);
        bflg_out_t          res;
        logic [LEVEL_W-1:0] pct;
        logic [LEVEL_W-1:0] filt;
        res  = '0;
        pct  = (w.raw_percent > PCT_MAX) ? PCT_MAX : w.raw_percent[LEVEL_W-1:0];
        // only on battery and charging take a sample; complete and status three hold
        if (w.chg_state == CHG_NOT || w.chg_state == CHG_ING) begin
            filt = push_and_average(pct);
            // a held zero reloads before the direction rule
            if (hold_pct == '0) begin
                hold_pct = filt;
            end
            if (w.chg_state == CHG_NOT) begin
                if (filt < hold_pct) begin
                    hold_pct = filt;
                end
            end else if (filt > hold_pct) begin
                hold_pct = filt;
            end
        end
        // low guard only runs on battery; other states keep the run count
        if (w.chg_state == CHG_NOT) begin
            res.unplug_event = (prev_status == CHG_ING || prev_status == CHG_DONE);
            if (hold_pct <= cfg_shut_pct) begin
                if (low_run != COUNT_MAX) begin
                    low_run++;
                end
                res.shutdown_request = (low_run > cfg_low_limit);
            end else begin
                low_run = '0;
            end
            res.low_warning = (hold_pct <= cfg_warn_pct);
        end
        prev_status = w.chg_state;
        res.level   = hold_pct;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued words, holds valid and payload until taken
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // s_data still holds the word taken at this edge
            if (s_valid && s_ready) begin
                level_expect.push_back(predict_level_word(s_data));
            end
            if (!s_valid || s_ready) begin
                if (word_queue.size() != 0 && int'($urandom_range(0, 99)) >= send_idle_pct) begin
                    s_data  <= word_queue.pop_front();
                    s_valid <= 1'b1;
                    words_issued++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random backpressure, one long hold-off, field-by-field check
    // ------------------------------------------------------------------
    int stall_left    = 0;
    bit pressure_done = 1'b0;

    task automatic check_result(input bflg_out_t got);
        bflg_out_t want;
        if (level_expect.size() == 0) begin
            $error("result word with nothing expected: level %0d", got.level);
            fail_count++;
        end else begin
            want = level_expect.pop_front();
            results_done++;
            if (got.level !== want.level) begin
                $error("level: expected %0d, actual %0d", want.level, got.level);
                fail_count++;
            end
            if (got.low_warning !== want.low_warning) begin
                $error("low_warning: expected %0b, actual %0b",
                       want.low_warning, got.low_warning);
                fail_count++;
            end
            if (got.shutdown_request !== want.shutdown_request) begin
                $error("shutdown_request: expected %0b, actual %0b",
                       want.shutdown_request, got.shutdown_request);
                fail_count++;
            end
            if (got.unplug_event !== want.unplug_event) begin
                $error("unplug_event: expected %0b, actual %0b",
                       want.unplug_event, got.unplug_event);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
                // hold the result side long enough to back the block up into its input
                if (!pressure_done && results_done == PRESSURE_AT) begin
                    stall_left    = PRESSURE_CYCLES;
                    pressure_done = 1'b1;
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (int'($urandom_range(0, 99)) >= recv_idle_pct);
            end
        end
    end

    // watchdog: any handshake or register write restarts the count
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("battery_level_filter_guard_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(input int raw, input logic [STATUS_W-1:0] st);
        bflg_in_t w;
        w.raw_percent = RAW_W'(raw);
        w.chg_state   = st;
        word_queue.push_back(w);
    endtask

    // gauge noise of a few percent around a trend, kept inside the raw field
    function automatic int jitter(input int lvl);
        int v;
        v = lvl + int'($urandom_range(0, 6)) - 3;
        if (v < 0) begin
            v = 0;
        end
        if (v > 255) begin
            v = 255;
        end
        return v;
    endfunction

    // mostly discharge and charge traces, with complete spells and junk in between
    task automatic queue_random(input int count);
        int made;
        int kind;
        int run_len;
        int lvl;
        made = 0;
        while (made < count) begin
            kind = int'($urandom_range(0, 99));
            if (kind < 55) begin
                // discharge trace, often near the bottom so the guard gets exercised
                run_len = int'($urandom_range(3, 30));
                lvl = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 20))
                                                  : int'($urandom_range(0, 110));
                for (int k = 0; k < run_len && made < count; k++) begin
                    queue_word(jitter(lvl), CHG_NOT);
                    made++;
                    lvl -= int'($urandom_range(0, 3));
                    if (lvl < 0) begin
                        lvl = 0;
                    end
                end
            end else if (kind < 85) begin
                // charge trace, sometimes ending in a complete spell
                run_len = int'($urandom_range(3, 20));
                lvl = int'($urandom_range(0, 100));
                for (int k = 0; k < run_len && made < count; k++) begin
                    queue_word(jitter(lvl), CHG_ING);
                    made++;
                    lvl += int'($urandom_range(0, 3));
                end
                if ($urandom_range(0, 1) == 1) begin
                    run_len = int'($urandom_range(1, 5));
                    for (int k = 0; k < run_len && made < count; k++) begin
                        queue_word(int'($urandom_range(0, 255)),
                                   ($urandom_range(0, 9) == 0) ? CHG_UNDEF : CHG_DONE);
                        made++;
                    end
                end
            end else begin
                // junk: any raw value, any status code
                run_len = int'($urandom_range(1, 6));
                for (int k = 0; k < run_len && made < count; k++) begin
                    queue_word(int'($urandom_range(0, 255)),
                               STATUS_W'($urandom_range(0, 3)));
                    made++;
                end
            end
        end
    endtask

    // every word handed out has been answered, then a quiet tail
    task automatic wait_drained();
        while (word_queue.size() != 0 || results_done != words_issued) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_SHUTDOWN_LEVEL:  cfg_shut_pct  = data[LEVEL_W-1:0];
            CFG_WARN_LEVEL:      cfg_warn_pct  = data[LEVEL_W-1:0];
            CFG_LOW_COUNT_LIMIT: cfg_low_limit = data;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // registers change only once the block has gone quiet
    task automatic run_phase(input int shut_pct, input int warn_pct, input int limit,
                             input int count);
        wait_drained();
        write_reg(CFG_SHUTDOWN_LEVEL, CFG_DAT_W'(shut_pct));
        write_reg(CFG_WARN_LEVEL, CFG_DAT_W'(warn_pct));
        write_reg(CFG_LOW_COUNT_LIMIT, CFG_DAT_W'(limit));
        queue_random(count);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles a little, receiver a lot
        send_idle_pct = 14;
        recv_idle_pct = 62;

        // directed words under reset register values
        queue_word(0, CHG_NOT);      // first sample zero, held stays zero
        queue_word(255, CHG_NOT);    // top of raw range clamps, held zero reloads
        queue_word(101, CHG_ING);    // first trimmed mean, charging may rise
        queue_word(100, CHG_DONE);   // complete: no sample, level repeats
        queue_word(50, CHG_UNDEF);   // meaningless status takes no sample, like complete
        queue_word(0, CHG_NOT);      // after status three: no unplug
        queue_word(30, CHG_ING);
        queue_word(40, CHG_DONE);
        queue_word(20, CHG_NOT);     // unplug after complete
        queue_word(60, CHG_ING);
        queue_word(5, CHG_NOT);      // unplug after charging
        // flush the window with zeros: warning, low run past the limit, shutdown
        for (int k = 0; k < 10; k++) begin
            queue_word(0, CHG_NOT);
        end
        queue_word(1, CHG_NOT);
        queue_word(200, CHG_ING);
        queue_word(128, CHG_NOT);
        queue_word(7, CHG_DONE);

        run_phase(20, 30, 5, 400);
        // everything on battery counts low: run count saturates, limit just below full
        run_phase(127, 127, 254, 350);

        // now the sender idles a lot, the receiver a little
        send_idle_pct = 62;
        recv_idle_pct = 14;
        run_phase(0, 0, 0, 250);
        run_phase(100, 100, 255, 250);

        // no idling; the long hold-off lands in this phase
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(50, 60, 1, 300);

        wait_drained();
        if (fail_count == 0 && level_expect.size() == 0) begin
            $display("battery_level_filter_guard_tb: PASS");
        end else begin
            $display("battery_level_filter_guard_tb: FAIL");
        end
        $finish;
    end

endmodule
